@@ hdl/i2da_pkg.sv @@
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII converter.
// ----------------------------------------------------------------------------
package i2da_pkg;

  localparam int VALUE_W     = 32;
  localparam int DIGITS      = 10;
  localparam int BCD_W       = DIGITS * 4;
  localparam int IDX_W       = $clog2(DIGITS);
  localparam int STEP_W      = $clog2(VALUE_W);
  localparam int CHAR_W      = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_NINE  = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 7'h2D;

  typedef struct packed {
    logic               negative;
    logic [VALUE_W-1:0] mag;
  } i2da_entry_t;

endpackage

@@ hdl/i2da_if.sv @@
// ----------------------------------------------------------------------------
// i2da interfaces
// Valid/ready channels for input values and output characters.
// ----------------------------------------------------------------------------
interface i2da_in_if;
  import i2da_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface i2da_out_if;
  import i2da_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

@@ hdl/int_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// int_to_decimal_ascii_core
// Signed 32-bit integer to decimal ASCII text, one character per transaction.
// ----------------------------------------------------------------------------
// Each value on number becomes its decimal text on text, most significant
// character first, with a leading '-' for negative values and last_char set on
// the final character. In the back end each value is loaded, goes through 32
// shift-add-3 steps and a leading-digit step, then gives its 1 to 11 characters
// one per transaction; the back end takes no new value until it has emitted the
// last character of the previous one. The front register and a two-entry queue take
// up to three further values while a conversion runs or a character waits.
module int_to_decimal_ascii_core
  import i2da_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  i2da_in_if.sink    number,
  i2da_out_if.source text
);

  i2da_entry_t push_entry;
  logic        push_valid;
  logic        push_ready;
  i2da_entry_t pop_entry;
  logic        pop_valid;
  logic        pop_ready;

  i2da_front u_front (
    .clk        (clk),
    .rst        (rst),
    .number     (number),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready)
  );

  i2da_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_entry (push_entry),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .pop_entry  (pop_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready)
  );

  i2da_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_entry (pop_entry),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .text      (text)
  );

endmodule

@@ hdl/i2da_front.sv @@
// ----------------------------------------------------------------------------
// i2da_front
// Accepts input values, splits them into sign and unsigned magnitude.
// ----------------------------------------------------------------------------
module i2da_front
  import i2da_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  i2da_in_if.sink      number,
  output i2da_entry_t  push_entry,
  output logic         push_valid,
  input  logic         push_ready
);

  logic               held;
  i2da_entry_t        entry;
  logic [VALUE_W-1:0] raw;

  assign raw          = VALUE_W'(number.value);
  assign number.ready = !held || push_ready;
  assign push_valid   = held;
  assign push_entry   = entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (number.ready) begin
      held <= number.valid;
    end
  end

  // most negative value maps onto itself, read as unsigned
  always_ff @(posedge clk) begin
    if (number.valid && number.ready) begin
      entry.negative <= raw[VALUE_W-1];
      entry.mag      <= raw[VALUE_W-1] ? (~raw + VALUE_W'(1)) : raw;
    end
  end

endmodule

@@ hdl/i2da_queue.sv @@
// ----------------------------------------------------------------------------
// i2da_queue
// Small FIFO between the classify front end and the conversion back end.
// ----------------------------------------------------------------------------
module i2da_queue
  import i2da_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  i2da_entry_t push_entry,
  input  logic        push_valid,
  output logic        push_ready,
  output i2da_entry_t pop_entry,
  output logic        pop_valid,
  input  logic        pop_ready
);

  i2da_entry_t       mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_entry  = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

@@ hdl/i2da_back.sv @@
// ----------------------------------------------------------------------------
// i2da_back
// Shift-add-3 binary to BCD conversion, then character emission.
// ----------------------------------------------------------------------------
module i2da_back
  import i2da_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  i2da_entry_t pop_entry,
  input  logic        pop_valid,
  output logic        pop_ready,
  i2da_out_if.source  text
);

  typedef enum logic [3:0] {
    ST_IDLE    = 4'b0001,
    ST_CONVERT = 4'b0010,
    ST_LOCATE  = 4'b0100,
    ST_EMIT    = 4'b1000
  } state_t;

  state_t                    state;
  state_t                    state_next;
  logic [DIGITS-1:0][3:0]    bcd;
  logic [DIGITS-1:0][3:0]    bcd_adj;
  logic [BCD_W-1:0]          bcd_step;
  logic [VALUE_W-1:0]        mag;
  logic [VALUE_W-1:0]        mag_step;
  logic [STEP_W-1:0]         step;
  logic [IDX_W-1:0]          idx;
  logic [IDX_W-1:0]          lead;
  logic                      sign_pending;
  logic                      out_free;
  logic                      last_step;

  assign pop_ready = state == ST_IDLE;
  assign out_free  = !text.valid || text.ready;
  assign last_step = step == STEP_W'(VALUE_W - 1);

  // one double-dabble step: correct every digit, then shift in the next bit
  always_comb begin
    for (int i = 0; i < DIGITS; i++) begin
      bcd_adj[i] = (bcd[i] >= 4'd5) ? bcd[i] + 4'd3 : bcd[i];
    end
    {bcd_step, mag_step} = {bcd_adj[DIGITS-1:0], mag} << 1;
  end

  always_comb begin
    lead = '0;
    for (int i = 0; i < DIGITS; i++) begin
      if (bcd[i] != 4'd0) begin
        lead = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          state_next = ST_CONVERT;
        end
      end
      ST_CONVERT: begin
        if (last_step) begin
          state_next = ST_LOCATE;
        end
      end
      ST_LOCATE: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free && !sign_pending && idx == '0) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      text.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_free) begin
        text.valid <= state == ST_EMIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (pop_valid) begin
          mag          <= pop_entry.mag;
          sign_pending <= pop_entry.negative;
          bcd          <= '0;
          step         <= '0;
        end
      end
      ST_CONVERT: begin
        bcd  <= bcd_step;
        mag  <= mag_step;
        step <= step + STEP_W'(1);
      end
      ST_LOCATE: begin
        idx <= lead;
      end
      ST_EMIT: begin
        if (out_free) begin
          if (sign_pending) begin
            text.char_code <= CHAR_MINUS;
            text.last_char <= 1'b0;
            sign_pending   <= 1'b0;
          end else begin
            text.char_code <= CHAR_ZERO + CHAR_W'(bcd[idx]);
            text.last_char <= idx == '0;
            idx            <= idx - IDX_W'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/i2da_checker.sv @@
// ----------------------------------------------------------------------------
// i2da_checker
// Port-level checks on the character stream of the converter.
// ----------------------------------------------------------------------------
module i2da_checker
  import i2da_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              text_valid,
  input logic              text_ready,
  input logic [CHAR_W-1:0] text_char_code,
  input logic              text_last_char
);

  logic mid_number;

  // set once a character that is not the last one has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      mid_number <= 1'b0;
    end else if (text_valid && text_ready) begin
      mid_number <= !text_last_char;
    end
  end

  a_hold_valid: assert property (@(posedge clk) disable iff (rst)
    text_valid && !text_ready |=> text_valid)
    else $error("character transaction dropped while stalled");

  a_char_set: assert property (@(posedge clk) disable iff (rst)
    text_valid |-> (text_char_code == CHAR_MINUS ||
                    (text_char_code >= CHAR_ZERO && text_char_code <= CHAR_NINE)))
    else $error("character is neither minus nor digit");

  a_minus_not_last: assert property (@(posedge clk) disable iff (rst)
    text_valid && text_char_code == CHAR_MINUS |-> !text_last_char)
    else $error("minus sign ends a number");

  a_minus_first: assert property (@(posedge clk) disable iff (rst)
    text_valid && mid_number |-> text_char_code != CHAR_MINUS)
    else $error("minus sign inside a number");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !text_valid)
    else $error("character valid right after reset");

endmodule

bind int_to_decimal_ascii_core i2da_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .text_valid     (text.valid),
  .text_ready     (text.ready),
  .text_char_code (text.char_code),
  .text_last_char (text.last_char)
);
